@@ sv/segmented_allocation_map_macros.svh @@
// ============================================================================
// Assertion macros for the segmented allocation map
// Concurrent checks sampled on clk, held off while rst_n is low.
// ============================================================================
`ifndef SEGMENTED_ALLOCATION_MAP_MACROS_SVH
`define SEGMENTED_ALLOCATION_MAP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define SAM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define SAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAM_ASSERT_IMPL(lbl, ante, cons, msg)
`define SAM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/sam_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sam_pkg
// Shared constants, types and helper functions of the segmented allocation map.
// ============================================================================
package sam_pkg;

    localparam int NUM_SEGMENTS      = 100;
    localparam int SEGMENT_LOCATIONS = 1000;
    localparam int MARK_WORD_BITS    = 64;

    localparam int WORDS_PER_SEG = (SEGMENT_LOCATIONS + MARK_WORD_BITS - 1) / MARK_WORD_BITS;
    localparam int MARK_DEPTH    = NUM_SEGMENTS * WORDS_PER_SEG;
    localparam int ADDR_W        = $clog2(MARK_DEPTH);
    localparam int SEG_W         = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int WORD_CNT_W    = $clog2(WORDS_PER_SEG);
    localparam int WORD_IDX_W    = $clog2(MARK_WORD_BITS);

    // Request field and decoded field widths
    localparam int REQ_W       = 27;
    localparam int SEG_FIELD_W = 8;   // request / 1000000 stays below 135
    localparam int BASE_W      = 10;
    localparam int LEN_W       = 10;
    localparam int END_W       = 11;  // base + length
    localparam int QUO_W       = 10;

    localparam int SEG_DIVISOR  = 1000000;
    localparam int BASE_DIVISOR = 1000;
    localparam int ALLOC_LIMIT  = 999;

    // Reciprocals for constant division; the estimate is exact or one low
    localparam int SEG_SHIFT    = 47;
    localparam longint unsigned SEG_RECIP = (64'd1 << SEG_SHIFT) / 64'd1000000;
    localparam int SEG_RECIP_W  = 28;
    localparam int BASE_SHIFT   = 30;
    localparam longint unsigned BASE_RECIP = (64'd1 << BASE_SHIFT) / 64'd1000;
    localparam int BASE_RECIP_W = 21;
    localparam int PROD_W       = REQ_W + SEG_RECIP_W;
    localparam int REM_W        = 21;  // remainder before correction, below 2000000
    localparam int NUM2_W       = 20;  // remainder after correction, below 1000000

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_ACCESS = 1'b1;

    typedef struct packed {
        logic                   valid;
        logic                   op;
        logic [SEG_FIELD_W-1:0] seg;
        logic [BASE_W-1:0]      base;
        logic [LEN_W-1:0]       len;
    } dec_item_t;

    typedef struct packed {
        logic done;
        logic status;
    } walk_rsp_t;

    function automatic logic [ADDR_W-1:0] mark_addr(
        input logic [SEG_W-1:0]      seg,
        input logic [WORD_CNT_W-1:0] word
    );
        return ADDR_W'(seg) * ADDR_W'(WORDS_PER_SEG) + ADDR_W'(word);
    endfunction

    // Bits of one mark word whose locations fall in [lo, hi)
    function automatic logic [MARK_WORD_BITS-1:0] range_mask(
        input logic [WORD_CNT_W-1:0] word,
        input logic [BASE_W-1:0]     lo,
        input logic [END_W-1:0]      hi
    );
        logic [MARK_WORD_BITS-1:0] m;
        logic [END_W-1:0]          loc;
        for (int i = 0; i < MARK_WORD_BITS; i++)
        begin
            loc  = (END_W'(word) << WORD_IDX_W) + END_W'(i);
            m[i] = (loc >= END_W'(lo)) && (loc < hi);
        end
        return m;
    endfunction

endpackage

@@ sv/segmented_allocation_map.sv @@
// A command is decoded by constant division and its range is then walked over the
// mark words (up to 16, all 16 on first allocation of a segment); no words are walked
// when the decoded fields settle the answer. A new command is taken the cycle after the
// result moves to the output register: one mark memory word per cycle sets the pace,
// behind the multiply/subtract/adjust decode. Reset clears segment presence at once.
`timescale 1ns / 1ps
`include "segmented_allocation_map_macros.svh"
// ============================================================================
// segmented_allocation_map
// Allocates and checks location ranges in per-segment mark maps.
// ============================================================================
module segmented_allocation_map import sam_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  logic             op,
    input  logic [REQ_W-1:0] request,
    output logic             result_valid,
    input  logic             result_ready,
    output logic             status
);

    logic      busy_reg;
    logic      result_valid_reg;
    logic      status_reg;
    logic      cmd_fire;
    logic      load;
    dec_item_t dec_item;
    walk_rsp_t rsp;

    // One command in the engine at a time; the output register lets it
    // take the next command while a result still waits.
    assign cmd_ready = !busy_reg;
    assign cmd_fire  = cmd_valid && cmd_ready;

    // Move a finished result into the output register when it is empty
    // or being drained in this cycle; otherwise hold the walker in its done state.
    assign load = rsp.done && (!result_valid_reg || result_ready);

    sam_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd_fire),
        .op      (op),
        .request (request),
        .item    (dec_item)
    );

    sam_walk u_walk
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (dec_item),
        .ack   (load),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
                busy_reg <= 1'b1;
            else if (load)
                busy_reg <= 1'b0;

            if (load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Status payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
            status_reg <= rsp.status;
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;

    `SAM_ASSERT_IMPL(a_work_only_when_busy, dec_item.valid || rsp.done, busy_reg, "engine active while idle")
    `SAM_ASSERT_IMPL(a_accept_into_empty, cmd_fire, !dec_item.valid && !rsp.done, "command taken while engine occupied")

endmodule

@@ sv/sam_decode.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sam_decode
// Splits a decimal-packed request into segment, base and length by
// reciprocal multiplication with one correction step per digit group.
// ============================================================================
module sam_decode import sam_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             op,
    input  logic [REQ_W-1:0] request,
    output dec_item_t        item
);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_MUL1 = 3'd1;
    localparam logic [2:0] D_SUB1 = 3'd2;
    localparam logic [2:0] D_ADJ1 = 3'd3;
    localparam logic [2:0] D_MUL2 = 3'd4;
    localparam logic [2:0] D_SUB2 = 3'd5;
    localparam logic [2:0] D_ADJ2 = 3'd6;

    logic [2:0]             state_reg;
    logic                   valid_reg;
    logic [REQ_W-1:0]       num_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [QUO_W-1:0]       quo_reg;
    logic [REM_W-1:0]       rem_reg;
    logic                   op_reg;
    logic [SEG_FIELD_W-1:0] seg_reg;
    logic [BASE_W-1:0]      base_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [SEG_FIELD_W-1:0] q_seg;
    logic [QUO_W-1:0]       q_base;

    assign q_seg  = SEG_FIELD_W'(prod_reg >> SEG_SHIFT);
    assign q_base = QUO_W'(prod_reg >> BASE_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: if (start) state_reg <= D_MUL1;
                D_MUL1: state_reg <= D_SUB1;
                D_SUB1: state_reg <= D_ADJ1;
                D_ADJ1: state_reg <= D_MUL2;
                D_MUL2: state_reg <= D_SUB2;
                D_SUB2: state_reg <= D_ADJ2;
                D_ADJ2:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    num_reg <= request;
                    op_reg  <= op;
                end
            end
            D_MUL1: prod_reg <= PROD_W'(num_reg) * PROD_W'(SEG_RECIP);
            D_SUB1:
            begin
                quo_reg <= QUO_W'(q_seg);
                rem_reg <= REM_W'(num_reg - REQ_W'(q_seg) * REQ_W'(SEG_DIVISOR));
            end
            D_ADJ1:
            begin
                // Estimate may be one low: fold the excess back
                if (rem_reg >= REM_W'(SEG_DIVISOR))
                begin
                    seg_reg <= SEG_FIELD_W'(quo_reg) + SEG_FIELD_W'(1);
                    num_reg <= REQ_W'(rem_reg - REM_W'(SEG_DIVISOR));
                end
                else
                begin
                    seg_reg <= SEG_FIELD_W'(quo_reg);
                    num_reg <= REQ_W'(rem_reg);
                end
            end
            D_MUL2: prod_reg <= PROD_W'(num_reg[NUM2_W-1:0]) * PROD_W'(BASE_RECIP);
            D_SUB2:
            begin
                quo_reg <= q_base;
                rem_reg <= REM_W'(num_reg[NUM2_W-1:0]
                           - NUM2_W'(q_base) * NUM2_W'(BASE_DIVISOR));
            end
            D_ADJ2:
            begin
                if (rem_reg >= REM_W'(BASE_DIVISOR))
                begin
                    base_reg <= BASE_W'(quo_reg) + BASE_W'(1);
                    len_reg  <= LEN_W'(rem_reg - REM_W'(BASE_DIVISOR));
                end
                else
                begin
                    base_reg <= BASE_W'(quo_reg);
                    len_reg  <= LEN_W'(rem_reg);
                end
            end
            default: ;
        endcase
    end

    assign item.valid = valid_reg;
    assign item.op    = op_reg;
    assign item.seg   = seg_reg;
    assign item.base  = base_reg;
    assign item.len   = len_reg;

endmodule

@@ sv/sam_walk.sv @@
`timescale 1ns / 1ps
`include "segmented_allocation_map_macros.svh"
// ============================================================================
// sam_walk
// Holds segment presence and the mark memory; walks the mark words of a range
// by pipelined read-modify-write (read-and-check on access), one word per cycle.
// ============================================================================
module sam_walk import sam_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dec_item_t item,
    input  logic      ack,
    output walk_rsp_t rsp
);

    localparam logic [1:0] W_IDLE = 2'd0;
    localparam logic [1:0] W_WALK = 2'd1;
    localparam logic [1:0] W_DONE = 2'd2;

    logic [MARK_WORD_BITS-1:0] mark_mem [MARK_DEPTH];
    logic [MARK_WORD_BITS-1:0] rd_data_reg;

    logic [1:0]              state_reg;
    logic [NUM_SEGMENTS-1:0] present_reg;
    logic                    fault_reg;
    logic                    op_reg;
    logic                    fresh_reg;
    logic [SEG_W-1:0]        seg_reg;
    logic [BASE_W-1:0]       base_reg;
    logic [END_W-1:0]        end_reg;
    logic [WORD_CNT_W-1:0]   word_reg;
    logic [WORD_CNT_W-1:0]   last_word_reg;
    logic                    issuing_reg;
    logic                    pend_valid_reg;
    logic [WORD_CNT_W-1:0]   pend_word_reg;
    logic                    pend_last_reg;

    logic                      seg_ok;
    logic [SEG_W-1:0]          seg_idx;
    logic                      seg_live;
    logic [END_W-1:0]          item_end;
    logic [WORD_CNT_W-1:0]     first_word;
    logic [WORD_CNT_W-1:0]     last_word;
    logic                      alloc_bad;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [MARK_WORD_BITS-1:0] mask;
    logic [MARK_WORD_BITS-1:0] old_word;
    logic [MARK_WORD_BITS-1:0] wr_data;

    always_comb
    begin
        seg_ok     = item.seg < SEG_FIELD_W'(NUM_SEGMENTS);
        seg_idx    = SEG_W'(item.seg);
        seg_live   = seg_ok && present_reg[seg_idx];
        item_end   = END_W'(item.base) + END_W'(item.len);
        first_word = WORD_CNT_W'(item.base >> WORD_IDX_W);
        last_word  = WORD_CNT_W'((item_end - END_W'(1)) >> WORD_IDX_W);
        alloc_bad  = (item_end >= END_W'(ALLOC_LIMIT)) || !seg_ok;
    end

    // A fresh segment ignores whatever the memory held
    always_comb
    begin
        rd_en    = (state_reg == W_WALK) && issuing_reg && !fresh_reg;
        rd_addr  = mark_addr(seg_reg, word_reg);
        mask     = range_mask(pend_word_reg, base_reg, end_reg);
        old_word = fresh_reg ? '0 : rd_data_reg;
        wr_en    = (state_reg == W_WALK) && pend_valid_reg && (op_reg == OP_ALLOC);
        wr_addr  = mark_addr(seg_reg, pend_word_reg);
        wr_data  = old_word | mask;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mark_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mark_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= W_IDLE;
            present_reg    <= '0;
            fault_reg      <= 1'b0;
            op_reg         <= OP_ALLOC;
            fresh_reg      <= 1'b0;
            seg_reg        <= '0;
            base_reg       <= '0;
            end_reg        <= '0;
            word_reg       <= '0;
            last_word_reg  <= '0;
            issuing_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_word_reg  <= '0;
            pend_last_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                W_IDLE:
                begin
                    if (item.valid)
                    begin
                        op_reg      <= item.op;
                        seg_reg     <= seg_idx;
                        base_reg    <= item.base;
                        end_reg     <= item_end;
                        fault_reg   <= 1'b0;
                        fresh_reg   <= 1'b0;
                        word_reg    <= first_word;
                        last_word_reg <= last_word;
                        if (item.op == OP_ALLOC)
                        begin
                            if (alloc_bad)
                            begin
                                fault_reg <= 1'b1;
                                state_reg <= W_DONE;
                            end
                            else
                            begin
                                present_reg[seg_idx] <= 1'b1;
                                if (!seg_live)
                                begin
                                    // New segment: write every word of its map
                                    fresh_reg     <= 1'b1;
                                    word_reg      <= '0;
                                    last_word_reg <= WORD_CNT_W'(WORDS_PER_SEG - 1);
                                    issuing_reg   <= 1'b1;
                                    state_reg     <= W_WALK;
                                end
                                else if (item.len == '0)
                                    state_reg <= W_DONE;
                                else
                                begin
                                    issuing_reg <= 1'b1;
                                    state_reg   <= W_WALK;
                                end
                            end
                        end
                        else
                        begin
                            if (!seg_live)
                            begin
                                fault_reg <= 1'b1;
                                state_reg <= W_DONE;
                            end
                            else if (item.len == '0)
                                state_reg <= W_DONE;
                            else if (item_end > END_W'(SEGMENT_LOCATIONS))
                            begin
                                fault_reg <= 1'b1;
                                state_reg <= W_DONE;
                            end
                            else
                            begin
                                issuing_reg <= 1'b1;
                                state_reg   <= W_WALK;
                            end
                        end
                    end
                end
                W_WALK:
                begin
                    // Issue side; it has stopped by the time the last word returns
                    pend_valid_reg <= issuing_reg;
                    pend_word_reg  <= word_reg;
                    pend_last_reg  <= (word_reg == last_word_reg);
                    if (issuing_reg)
                    begin
                        if (word_reg == last_word_reg)
                            issuing_reg <= 1'b0;
                        else
                            word_reg <= word_reg + WORD_CNT_W'(1);
                    end
                    // Return side
                    if (pend_valid_reg)
                    begin
                        if ((op_reg == OP_ACCESS) && ((rd_data_reg & mask) != mask))
                            fault_reg <= 1'b1;
                        if (pend_last_reg)
                        begin
                            state_reg <= W_DONE;
                        end
                    end
                end
                W_DONE:
                begin
                    if (ack)
                        state_reg <= W_IDLE;
                end
                default: state_reg <= W_IDLE;
            endcase
        end
    end

    assign rsp.done   = (state_reg == W_DONE);
    assign rsp.status = fault_reg;

    `SAM_ASSERT_IMPL(a_no_rw_clash, rd_en && wr_en, rd_addr != wr_addr, "read and write hit one word")
    `SAM_ASSERT_IMPL(a_done_drained, state_reg == W_DONE, !pend_valid_reg && !issuing_reg, "walk left words in flight")
    `SAM_ASSERT_NEXT(a_alloc_marks_present, (state_reg == W_IDLE) && item.valid && (item.op == OP_ALLOC) && !alloc_bad, present_reg[$past(seg_idx)], "allocated segment not present")

endmodule
